/* rtl/core/irefc_pkg.sv */
// Shared types and constants for the IR edge-interval frame capture block.
// Depends on nothing; imported by ir_edge_interval_frame_capture.
package irefc_pkg;

	// Interval store geometry
	localparam int MAX_EDGES       = 64;
	localparam int IDX_W           = $clog2(MAX_EDGES);
	localparam int COUNT_W         = $clog2(MAX_EDGES + 1);
	localparam int MIN_FRAME_EDGES = 4;

	// Timeout handling: threshold held in microseconds
	localparam int US_PER_MS       = 1000;
	localparam int TIMEOUT_MS_W    = 7;
	localparam int TIMEOUT_RESET   = 10;
	localparam int THR_W           = $clog2(((1 << TIMEOUT_MS_W) - 1) * US_PER_MS + 1);
	localparam int ENTRY_W         = 16;

	// Configuration port
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = TIMEOUT_MS_W;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 1'd1;

	// Operation codes
	localparam logic [1:0] OP_EDGE    = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_RELEASE = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] now_us;
		logic        pin_level;
		logic [5:0]  entry_index;
	} in_word_t;

	typedef struct packed {
		logic        frame_ready;
		logic [6:0]  edge_count;
		logic        first_edge_level;
		logic [31:0] frame_time_us;
		logic [15:0] entry_us;
	} out_word_t;

endpackage

/* rtl/core/ir_edge_interval_frame_capture.sv */
// IR edge-interval frame capture: top level with timing state, interval store
// and output register. Depends on irefc_pkg.
//
//   channel  | handshake             | word
//   ---------+-----------------------+-----------------------------------------
//   in       | in_valid / in_ready   | in_word  (operation, now_us, level, index)
//   out      | out_valid / out_ready | out_word (ready, count, level, time, entry)
//   cfg      | cfg_we                | cfg_index, cfg_data (write only)
//
// One word per cycle sustained while out_ready stays high.
// A word is registered at s1 with its store read already issued; state is
// updated and the result registered as s1 moves into the output register.
// The input side stalls only while s1 is full and the output word is unread.
// Reset clears all timing state; the interval store needs no clearing pass.
module ir_edge_interval_frame_capture (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  irefc_pkg::in_word_t                 in_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output irefc_pkg::out_word_t                out_word,
	input  logic                                cfg_we,
	input  logic [irefc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [irefc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import irefc_pkg::*;

	// Configuration
	logic             enable_q;
	logic [THR_W-1:0] thr_q;

	// Capture state
	logic               started_q;
	logic [31:0]        last_q;
	logic [COUNT_W-1:0] icount_q;
	logic               first_level_q;
	logic               held_q;
	logic [COUNT_W-1:0] held_count_q;
	logic [31:0]        close_q;

	// Pipeline
	logic                 valid_s1;
	in_word_t             word_s1;
	logic [ENTRY_W-1:0]   rd_s1;
	logic                 advance;
	logic                 in_accept;

	// Interval store
	logic [ENTRY_W-1:0] store_mem [MAX_EDGES];
	logic               mem_we;
	logic [IDX_W-1:0]   mem_addr;
	logic [ENTRY_W-1:0] mem_wdata;

	// Next-state values
	logic               started_d;
	logic [31:0]        last_d;
	logic [COUNT_W-1:0] icount_d;
	logic               first_level_d;
	logic               held_d;
	logic [COUNT_W-1:0] held_count_d;
	logic [31:0]        close_d;
	logic [ENTRY_W-1:0] entry_d;
	logic [31:0]        gap;
	logic               gap_long;
	logic               do_close;

	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_accept = in_valid && in_ready;

	// Configuration writes; threshold kept in microseconds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			thr_q    <= THR_W'(TIMEOUT_RESET * US_PER_MS);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:     enable_q <= cfg_data[0];
				REG_TIMEOUT_MS: thr_q    <= THR_W'(cfg_data) * THR_W'(US_PER_MS);
				default:        ;
			endcase
		end
	end

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			word_s1 <= in_word;
		end
	end

	// Store: read issued on accept, written as an edge word leaves s1
	always_ff @(posedge clk) begin
		if (in_accept) begin
			rd_s1 <= store_mem[in_word.entry_index[IDX_W-1:0]];
		end
		if (mem_we) begin
			store_mem[mem_addr] <= mem_wdata;
		end
	end

	// Gap against the previous edge, wrapping
	assign gap       = word_s1.now_us - last_q;
	assign gap_long  = gap > 32'(thr_q);
	assign mem_addr  = icount_q[IDX_W-1:0];
	assign mem_wdata = (gap > 32'(16'hFFFF)) ? 16'hFFFF : gap[ENTRY_W-1:0];

	// Step logic for the word in s1
	always_comb begin
		started_d     = started_q;
		last_d        = last_q;
		icount_d      = icount_q;
		first_level_d = first_level_q;
		held_d        = held_q;
		held_count_d  = held_count_q;
		close_d       = close_q;
		entry_d       = '0;
		mem_we        = 1'b0;
		do_close      = 1'b0;

		case (word_s1.operation)
			OP_EDGE: begin
				if (enable_q && !held_q) begin
					if (!started_q) begin
						started_d     = 1'b1;
						first_level_d = word_s1.pin_level;
					end else if (gap_long) begin
						do_close = 1'b1;
					end else if (icount_q < COUNT_W'(MAX_EDGES)) begin
						mem_we   = advance;
						icount_d = icount_q + COUNT_W'(1);
					end
					last_d = word_s1.now_us;
				end
			end
			OP_TICK: begin
				if (enable_q && !held_q && icount_q != '0 && gap_long) begin
					do_close  = 1'b1;
					started_d = 1'b0;
					last_d    = '0;
				end
			end
			OP_READ: begin
				if (held_q && COUNT_W'(word_s1.entry_index) < held_count_q) begin
					entry_d = rd_s1;
				end
			end
			OP_RELEASE: begin
				if (held_q) begin
					held_d       = 1'b0;
					held_count_d = '0;
					icount_d     = '0;
					started_d    = 1'b0;
					last_d       = '0;
				end
			end
			default: ;
		endcase

		// Frame close: keep it only with enough edges
		if (do_close) begin
			if (icount_q >= COUNT_W'(MIN_FRAME_EDGES)) begin
				held_d       = 1'b1;
				held_count_d = icount_q;
				close_d      = word_s1.now_us;
			end
			icount_d = '0;
		end
	end

	// State update as the word leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q     <= 1'b0;
			last_q        <= '0;
			icount_q      <= '0;
			first_level_q <= 1'b0;
			held_q        <= 1'b0;
			held_count_q  <= '0;
			close_q       <= '0;
		end else if (advance) begin
			started_q     <= started_d;
			last_q        <= last_d;
			icount_q      <= icount_d;
			first_level_q <= first_level_d;
			held_q        <= held_d;
			held_count_q  <= held_count_d;
			close_q       <= close_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word.frame_ready      <= held_d;
			out_word.edge_count       <= 7'(held_count_d);
			out_word.first_edge_level <= first_level_d;
			out_word.frame_time_us    <= close_d;
			out_word.entry_us         <= entry_d;
		end
	end

	// Checks
	a_held_min_edges: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> held_count_q >= COUNT_W'(MIN_FRAME_EDGES))
		else $error("held frame has too few edges");

	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!held_q |-> held_count_q == '0)
		else $error("held count set with no frame held");

	a_no_write_held: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !held_q && icount_q < COUNT_W'(MAX_EDGES))
		else $error("store written while frame held or full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		icount_q <= COUNT_W'(MAX_EDGES))
		else $error("interval count beyond store depth");

endmodule
